/* rtl/pdll_pkg.sv */
`timescale 1ns / 1ps
package pdll_pkg;
   localparam int NODES = 16;
   localparam int NW = $clog2(NODES);
   localparam int LW = NW + 1;
   localparam int VW = 32;
   localparam logic [LW-1:0] NIL = LW'(NODES);

   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_PREPEND = 3'd1;
   localparam logic [2:0] OP_INSERT  = 3'd2;
   localparam logic [2:0] OP_SEARCH  = 3'd3;
   localparam logic [2:0] OP_DELETE  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BAD     = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic load;
      logic alloc;
      logic walk_init;
      logic walk_step;
      logic unlink;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic pool_empty;
      logic target_ok;
      logic walk_hit;
      logic walk_end;
   } sts_type;
endpackage

/* rtl/pdll_datapath.sv */
`timescale 1ns / 1ps
module pdll_datapath
   import pdll_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic [1:0]    rsp_code,
   input  logic [2:0]    req_operation,
   input  logic [VW-1:0] req_value,
   input  logic [3:0]    req_target_node,
   output sts_type       sts,
   output logic          rsp_strobe,
   output logic [1:0]    rsp_status,
   output logic [3:0]    rsp_node
);
   logic [VW-1:0] val_ff   [NODES];
   logic [LW-1:0] next_ff  [NODES];
   logic [LW-1:0] prev_ff  [NODES];
   logic [LW-1:0] free_ff  [NODES];
   logic [NODES-1:0] used_ff;
   logic [LW-1:0] head_ff, tail_ff, top_ff, cur_ff;
   logic [LW-1:0] steps_ff;
   logic [2:0]    op_ff;
   logic [VW-1:0] v_ff;
   logic [3:0]    tgt_ff;
   logic          strobe_ff;
   logic [1:0]    status_ff;
   logic [3:0]    node_ff;
   logic [NW-1:0] ci, ti, ni;
   logic [LW-1:0] p, q, after;

   assign ci = cur_ff[NW-1:0];
   assign ti = tgt_ff[NW-1:0];
   assign ni = top_ff[NW-1:0];
   assign p = prev_ff[ci];
   assign q = next_ff[ci];
   assign after = next_ff[ti];

   assign sts.pool_empty = top_ff == NIL;
   assign sts.target_ok = (LW'(tgt_ff) < LW'(NODES)) && used_ff[ti];
   assign sts.walk_hit = val_ff[ci] == v_ff;
   assign sts.walk_end = (cur_ff == NIL) || (steps_ff == LW'(NODES));

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= NIL;
         tail_ff <= NIL;
         top_ff <= '0;
         used_ff <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < NODES; i++) begin
            val_ff[i] <= '0;
            next_ff[i] <= NIL;
            prev_ff[i] <= NIL;
            free_ff[i] <= LW'(i + 1);
         end
      end else begin
         strobe_ff <= cmd.respond;
         if (cmd.respond) begin
            status_ff <= rsp_code;
            node_ff <= (rsp_code == ST_OK) ?
                       ((op_ff == OP_SEARCH || op_ff == OP_DELETE) ?
                        4'(cur_ff) : 4'(top_ff)) : 4'd0;
         end
         if (cmd.load) begin
            op_ff <= req_operation;
            v_ff <= req_value;
            tgt_ff <= req_target_node;
         end
         if (cmd.alloc) begin
            top_ff <= free_ff[ni];
            val_ff[ni] <= v_ff;
            used_ff[ni] <= 1'b1;
            if (op_ff == OP_INSERT) begin
               prev_ff[ni] <= LW'(tgt_ff);
               next_ff[ni] <= after;
               next_ff[ti] <= top_ff;
               if (after != NIL) prev_ff[after[NW-1:0]] <= top_ff;
               else tail_ff <= top_ff;
            end else if (head_ff == NIL) begin
               next_ff[ni] <= NIL;
               prev_ff[ni] <= NIL;
               head_ff <= top_ff;
               tail_ff <= top_ff;
            end else if (op_ff == OP_APPEND) begin
               next_ff[ni] <= NIL;
               prev_ff[ni] <= tail_ff;
               next_ff[tail_ff[NW-1:0]] <= top_ff;
               tail_ff <= top_ff;
            end else begin
               next_ff[ni] <= head_ff;
               prev_ff[ni] <= NIL;
               prev_ff[head_ff[NW-1:0]] <= top_ff;
               head_ff <= top_ff;
            end
         end
         if (cmd.walk_init) begin
            cur_ff <= head_ff;
            steps_ff <= '0;
         end
         if (cmd.walk_step) begin
            cur_ff <= q;
            steps_ff <= steps_ff + 1'b1;
         end
         if (cmd.unlink) begin
            if (p != NIL) next_ff[p[NW-1:0]] <= q;
            else head_ff <= q;
            if (q != NIL) prev_ff[q[NW-1:0]] <= p;
            else tail_ff <= p;
            val_ff[ci] <= '0;
            next_ff[ci] <= NIL;
            prev_ff[ci] <= NIL;
            used_ff[ci] <= 1'b0;
            free_ff[ci] <= top_ff;
            top_ff <= cur_ff;
         end
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_node = node_ff;
endmodule

/* rtl/pdll_control.sv */
`timescale 1ns / 1ps
module pdll_control
   import pdll_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_start,
   input  logic [2:0] req_operation,
   input  sts_type    sts,
   output cmd_type    cmd,
   output logic [1:0] rsp_code,
   output logic       busy
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [2:0] op_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      if (cmd.load) op_ff <= req_operation;
   end

   always_comb begin
      cmd = '0;
      rsp_code = ST_OK;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               cmd.load = 1'b1;
               cmd.walk_init = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            cmd.respond = 1'b1;
            if (op_ff == OP_APPEND || op_ff == OP_PREPEND) begin
               if (sts.pool_empty) rsp_code = ST_FULL;
               else cmd.alloc = 1'b1;
            end else if (op_ff == OP_INSERT) begin
               if (!sts.target_ok) rsp_code = ST_BAD;
               else if (sts.pool_empty) rsp_code = ST_FULL;
               else cmd.alloc = 1'b1;
            end else if (op_ff == OP_SEARCH || op_ff == OP_DELETE) begin
               cmd.respond = 1'b0;
               state_in = S_WALK;
            end else begin
               rsp_code = ST_BAD;
            end
         end
         S_WALK: begin
            if (sts.walk_end) begin
               cmd.respond = 1'b1;
               rsp_code = ST_MISSING;
               state_in = S_IDLE;
            end else if (sts.walk_hit) begin
               cmd.respond = 1'b1;
               cmd.unlink = op_ff == OP_DELETE;
               state_in = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;
endmodule

/* rtl/pooled_doubly_linked_list_top.sv */
`timescale 1ns / 1ps
// Append, prepend, insert-after and unknown codes pass from the accepting edge through the
// decide state to the registered result; a new beat is taken only once busy has dropped.
// Search and delete also walk the list from the head, taking at most NODES walk steps.
// Busy drops as the result strobe rises; one beat is in work at a time.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Synchronous reset empties the list and rebuilds the free stack at once.
module pooled_doubly_linked_list_top
   import pdll_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [2:0]    req_operation,
   input  logic [VW-1:0] req_value,
   input  logic [3:0]    req_target_node,
   output logic          rsp_strobe,
   output logic [1:0]    rsp_status,
   output logic [3:0]    rsp_node
);
   cmd_type cmd;
   sts_type sts;
   logic [1:0] code;
   logic fsm_busy;

   assign busy = fsm_busy;

   pdll_control u_ctrl (
      .clock, .reset, .req_start(start), .req_operation, .sts, .cmd,
      .rsp_code(code), .busy(fsm_busy)
   );
   pdll_datapath u_dp (
      .clock, .reset, .cmd, .rsp_code(code), .req_operation, .req_value,
      .req_target_node, .sts, .rsp_strobe, .rsp_status, .rsp_node
   );
endmodule

/* rtl/pdll_checker.sv */
`timescale 1ns / 1ps
module pdll_checker
   import pdll_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_node
);
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("Accepted beat did not raise busy.");
   a_node: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> rsp_node == 4'd0)
      else $error("Failed beat carries a node.");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("Result strobe repeated.");
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("Result given while still busy.");
endmodule

bind pooled_doubly_linked_list_top pdll_checker u_chk (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_status, .rsp_node
);
